// ----- src/nftp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the nearest texel fetch block.
// No dependencies; nftp_front, nftp_back and the top level import this package.
package nftp_pkg;

   localparam int DEF_IMAGE_BYTES     = 65536;
   localparam int DEF_PALETTE_ENTRIES = 256;
   localparam int DEF_FRACTION_BITS   = 8;

   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 16;
   localparam int PIDX_W   = 8;
   localparam int WORD_W   = 32;
   localparam int COORD_W  = 24;
   localparam int POS_W    = 13;
   localparam int PITCH_W  = 15;
   localparam int FMT_W    = 3;
   localparam int ROW_W    = POS_W + PITCH_W;
   localparam int OFF_W    = POS_W + 2;
   localparam int REQ_DW   = 104;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int RSP_W    = WORD_W + 1;

   localparam int Q_DEPTH   = 4;
   localparam int OUT_DEPTH = 8;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
   localparam logic [2:0] REG_ROW_PITCH     = 3'd3;
   localparam logic [2:0] REG_PALETTE_VALID = 3'd4;

   localparam logic [FMT_W-1:0] FMT_BGRA32 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_PAL8   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_PAL4   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_PAL1   = 3'd3;

   typedef enum logic [FUNC_W-1:0] {
      KIND_IMG_WRITE = 2'd0,
      KIND_PAL_WRITE = 2'd1,
      KIND_SAMPLE    = 2'd2,
      KIND_NOP       = 2'd3
   } nftp_kind_type;

   typedef enum logic [2:0] {
      MODE_BGRA = 3'd0,
      MODE_PAL8 = 3'd1,
      MODE_PAL4 = 3'd2,
      MODE_PAL1 = 3'd3,
      MODE_BAD  = 3'd4
   } nftp_mode_type;

   typedef struct packed {
      logic [FMT_W-1:0]   pixel_format;
      logic [POS_W-1:0]   image_width;
      logic [POS_W-1:0]   image_height;
      logic [PITCH_W-1:0] row_pitch;
      logic               palette_valid;
   } nftp_cfg_type;

   typedef struct packed {
      nftp_kind_type      kind;
      nftp_mode_type      mode;
      logic [POS_W-1:0]   x_pos;
      logic [POS_W-1:0]   y_pos;
      logic [ADDR_W-1:0]  mem_address;
      logic [PIDX_W-1:0]  pal_index;
      logic [WORD_W-1:0]  write_data;
   } nftp_item_type;

endpackage

// ----- src/nftp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nftp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/nftp_fifo.sv -----
`timescale 1ns / 1ps
// Small synchronous FIFO in flip-flops; head word read straight from storage.
// No dependencies.
module nftp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/nftp_front.sv -----
`timescale 1ns / 1ps
// Front end: takes requests, classifies them, rounds and clamps coordinates.
// Depends on nftp_pkg; feeds the request queue.
module nftp_front import nftp_pkg::*; #(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  nftp_cfg_type        cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_DW-1:0]   req_tdata,
   input  logic [FUNC_W-1:0]   req_tuser,
   input  logic                q_full,
   output logic                q_push,
   output nftp_item_type       q_item
);

   localparam logic [COORD_W:0] Half = (COORD_W + 1)'((1 << FRACTION_BITS) >> 1);

   logic signed [COORD_W-1:0] x_coord, y_coord;
   nftp_mode_type             mode;

   // round half up, then clamp to [0, size-1]; size 0 acts as 1
   function automatic logic [POS_W-1:0] round_clamp(input logic [COORD_W-1:0] coord,
                                                    input logic [POS_W-1:0]   size);
      logic [COORD_W:0]   biased;
      logic [COORD_W-1:0] whole;
      logic [POS_W-1:0]   lim;
      logic [POS_W-1:0]   res;
      biased = {coord[COORD_W-1], coord} + Half;
      whole  = biased[COORD_W-1:0] >> FRACTION_BITS;
      lim    = (size == '0) ? '0 : size - 1'b1;
      if (biased[COORD_W]) begin
         res = '0;
      end else if (whole > COORD_W'(lim)) begin
         res = lim;
      end else begin
         res = POS_W'(whole);
      end
      return res;
   endfunction

   assign x_coord = $signed(req_tdata[79:56]);
   assign y_coord = $signed(req_tdata[103:80]);

   always_comb begin
      unique case (cfg.pixel_format)
         FMT_BGRA32: mode = MODE_BGRA;
         FMT_PAL8:   mode = cfg.palette_valid ? MODE_PAL8 : MODE_BAD;
         FMT_PAL4:   mode = cfg.palette_valid ? MODE_PAL4 : MODE_BAD;
         FMT_PAL1:   mode = cfg.palette_valid ? MODE_PAL1 : MODE_BAD;
         default:    mode = MODE_BAD;
      endcase
   end

   always_comb begin
      q_item.kind        = nftp_kind_type'(req_tuser);
      q_item.mode        = mode;
      q_item.x_pos       = round_clamp(x_coord, cfg.image_width);
      q_item.y_pos       = round_clamp(y_coord, cfg.image_height);
      q_item.mem_address = req_tdata[15:0];
      q_item.pal_index   = req_tdata[23:16];
      q_item.write_data  = req_tdata[55:24];
   end

   assign req_tready = !q_full;
   // no-operation requests are dropped here
   assign q_push     = req_tvalid && !q_full && (q_item.kind != KIND_NOP);

endmodule

// ----- src/nftp_back.sv -----
`timescale 1ns / 1ps
// Back end: address generation, banked image store, palette lookup, result queue.
// Depends on nftp_pkg, nftp_ram and nftp_fifo.
module nftp_back import nftp_pkg::*; #(
   parameter int IMAGE_BYTES     = DEF_IMAGE_BYTES,
   parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  nftp_cfg_type        cfg,
   input  logic                q_empty,
   input  nftp_item_type       q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,
   output logic [0:0]          rsp_tuser
);

   localparam int ImgAw     = $clog2(IMAGE_BYTES);
   localparam int BankDepth = IMAGE_BYTES / 4;
   localparam int BankAw    = ImgAw - 2;
   localparam int PalAw     = $clog2(PALETTE_ENTRIES);
   localparam int CntW      = $clog2(OUT_DEPTH + 1);

   // stage 1: address forming, image store access
   logic                s1_valid_ff;
   nftp_kind_type       s1_kind_ff;
   nftp_mode_type       s1_mode_ff;
   logic [POS_W-1:0]    s1_x_ff;
   logic [ImgAw-1:0]    s1_row_ff;
   logic [ADDR_W-1:0]   s1_maddr_ff;
   logic [PIDX_W-1:0]   s1_pal_ff;
   logic [WORD_W-1:0]   s1_data_ff;
   // stage 2: byte assembly, palette access
   logic                s2_valid_ff;
   nftp_kind_type       s2_kind_ff;
   nftp_mode_type       s2_mode_ff;
   logic [2:0]          s2_xlow_ff;
   logic [1:0]          s2_rot_ff;
   logic [PIDX_W-1:0]   s2_pal_ff;
   logic [WORD_W-1:0]   s2_data_ff;
   // stage 3: result select
   logic                s3_valid_ff;
   nftp_mode_type       s3_mode_ff;
   logic [WORD_W-1:0]   s3_bgra_ff;

   logic [CntW-1:0]     credit_ff, credit_in;
   logic [ROW_W-1:0]    row_prod;
   logic [OFF_W-1:0]    col_off;
   logic [ImgAw-1:0]    fetch_addr;
   logic [ImgAw-1:0]    wr_addr;
   logic [1:0]          lane_off  [4];
   logic [ImgAw-1:0]    lane_addr [4];
   logic [7:0]          bank_rd   [4];
   logic [7:0]          pix_byte  [4];
   logic [WORD_W-1:0]   bgra;
   logic [2:0]          bit_sel;
   logic [PIDX_W-1:0]   pal_idx;
   logic [WORD_W-1:0]   pal_rd;
   logic                pal_we;
   logic [WORD_W-1:0]   res_pixel;
   logic                res_bad;
   logic                pop_sample;
   logic                rsp_accept;
   logic [RSP_W-1:0]    out_head;
   logic                out_empty;

   // results are only launched while the output queue has room for them
   assign q_pop      = !q_empty &&
                       ((q_item.kind != KIND_SAMPLE) || (credit_ff < CntW'(OUT_DEPTH)));
   assign pop_sample = q_pop && (q_item.kind == KIND_SAMPLE);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign row_prod   = q_item.y_pos * cfg.row_pitch;

   always_comb begin
      credit_in = credit_ff;
      if (pop_sample && !rsp_accept) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_accept && !pop_sample) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && (s2_kind_ff == KIND_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= q_item.kind;
      s1_mode_ff  <= q_item.mode;
      s1_x_ff     <= q_item.x_pos;
      s1_row_ff   <= ImgAw'(row_prod);
      s1_maddr_ff <= q_item.mem_address;
      s1_pal_ff   <= q_item.pal_index;
      s1_data_ff  <= q_item.write_data;
   end

   // ---- stage 1 ----
   always_comb begin
      case (s1_mode_ff)
         MODE_BGRA: col_off = {s1_x_ff, 2'b00};
         MODE_PAL8: col_off = {2'b00, s1_x_ff};
         MODE_PAL4: col_off = {3'b000, s1_x_ff[POS_W-1:1]};
         MODE_PAL1: col_off = {5'b00000, s1_x_ff[POS_W-1:3]};
         default:   col_off = '0;
      endcase
   end

   assign fetch_addr = s1_row_ff + ImgAw'(col_off);
   assign wr_addr    = ImgAw'(s1_maddr_ff);

   // four byte banks: bytes addr..addr+3 always fall in distinct banks
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic bank_we;
      assign lane_off[b]  = 2'(b) - fetch_addr[1:0];
      assign lane_addr[b] = fetch_addr + ImgAw'(lane_off[b]);
      assign bank_we      = s1_valid_ff && (s1_kind_ff == KIND_IMG_WRITE) &&
                            (wr_addr[1:0] == 2'(b));

      nftp_ram #(
         .WIDTH (8),
         .DEPTH (BankDepth)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (wr_addr[ImgAw-1:2]),
         .wr_data (s1_data_ff[7:0]),
         .rd_addr (BankAw'(lane_addr[b][ImgAw-1:2])),
         .rd_data (bank_rd[b])
      );
   end

   always_ff @(posedge clock) begin
      s2_kind_ff <= s1_kind_ff;
      s2_mode_ff <= s1_mode_ff;
      s2_xlow_ff <= s1_x_ff[2:0];
      s2_rot_ff  <= fetch_addr[1:0];
      s2_pal_ff  <= s1_pal_ff;
      s2_data_ff <= s1_data_ff;
   end

   // ---- stage 2 ----
   always_comb begin
      logic [1:0] sel;
      for (int k = 0; k < 4; k++) begin
         sel         = s2_rot_ff + 2'(k);
         pix_byte[k] = bank_rd[sel];
      end
   end

   assign bgra    = {pix_byte[3], pix_byte[2], pix_byte[1], pix_byte[0]};
   assign bit_sel = 3'd7 - s2_xlow_ff;

   // high nibble first, MSB first
   always_comb begin
      case (s2_mode_ff)
         MODE_PAL8: pal_idx = pix_byte[0];
         MODE_PAL4: pal_idx = s2_xlow_ff[0] ? {4'h0, pix_byte[0][3:0]}
                                            : {4'h0, pix_byte[0][7:4]};
         MODE_PAL1: pal_idx = {7'b0, pix_byte[0][bit_sel]};
         default:   pal_idx = '0;
      endcase
   end

   assign pal_we = s2_valid_ff && (s2_kind_ff == KIND_PAL_WRITE);

   nftp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (PalAw'(s2_pal_ff)),
      .wr_data (s2_data_ff),
      .rd_addr (PalAw'(pal_idx)),
      .rd_data (pal_rd)
   );

   always_ff @(posedge clock) begin
      s3_mode_ff <= s2_mode_ff;
      s3_bgra_ff <= bgra;
   end

   // ---- stage 3 ----
   always_comb begin
      case (s3_mode_ff) inside
         MODE_BGRA: begin
            res_pixel = s3_bgra_ff;
            res_bad   = 1'b0;
         end
         MODE_PAL8, MODE_PAL4, MODE_PAL1: begin
            res_pixel = pal_rd;
            res_bad   = 1'b0;
         end
         default: begin
            res_pixel = '0;
            res_bad   = 1'b1;
         end
      endcase
   end

   nftp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data ({res_bad, res_pixel}),
      .full      (),
      .pop       (rsp_tready),
      .pop_data  (out_head),
      .empty     (out_empty)
   );

   assign rsp_tvalid = !out_empty;
   assign rsp_tdata  = out_head[WORD_W-1:0];
   assign rsp_tuser  = out_head[RSP_W-1 -: 1];

endmodule

// ----- src/nearest_texel_fetch_palette.sv -----
`timescale 1ns / 1ps
// Top level of the nearest texel fetch block: register file, front end,
// request queue and back end. Depends on nftp_pkg, nftp_front, nftp_fifo, nftp_back.
//
// Use:
//   req_* carries one request per handshake; req_tuser is the function
//   (image byte write, palette word write, sample, no-op). Writes and no-ops
//   give no response; a sample gives exactly one on rsp_*, in request order.
//   Samples round the Q.FRACTION_BITS coordinate half up and clamp it to the
//   image; rsp_tuser flags an unusable format or missing palette (pixel 0).
//   csr_* is an APB-style port for the five registers; write them only while
//   nothing is in flight.
// Timing:
//   One request per cycle sustained while the request queue has room. A sample's
//   response passes, in order, the queue pop, image bank read, palette read
//   and response queue before it shows on rsp_*. Image bytes sit in four byte
//   banks, so a 32-bit pixel at any byte address is one read of each bank.
// Reset and stall:
//   Reset restores the register defaults and empties both queues; image and
//   palette contents are undefined until written. While rsp_tready is low
//   up to 8 responses collect; past that the back end holds samples, the
//   4-entry request queue fills and req_tready drops.
module nearest_texel_fetch_palette import nftp_pkg::*; #(
   parameter int IMAGE_BYTES     = DEF_IMAGE_BYTES,
   parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
   parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request: tdata = mem_address[15:0], pal_index[23:16], write_data[55:24],
   //          x_coord[79:56], y_coord[103:80]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_DW-1:0]   req_tdata,
   input  logic [FUNC_W-1:0]   req_tuser,   // func[1:0]
   // response: tdata = pixel[31:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,
   output logic [0:0]          rsp_tuser,   // unsupported[0]
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int ItemW = $bits(nftp_item_type);

   logic [FMT_W-1:0]   fmt_ff;
   logic [POS_W-1:0]   width_ff;
   logic [POS_W-1:0]   height_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic               palv_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;
   nftp_cfg_type       cfg;

   logic               q_push, q_full, q_pop, q_empty;
   nftp_item_type      q_in_item;
   logic [ItemW-1:0]   q_head;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_BGRA32;
         width_ff  <= POS_W'(1);
         height_ff <= POS_W'(1);
         pitch_ff  <= PITCH_W'(4);
         palv_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PIXEL_FORMAT:  fmt_ff    <= csr_pwdata[FMT_W-1:0];
            REG_IMAGE_WIDTH:   width_ff  <= csr_pwdata[POS_W-1:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_pwdata[POS_W-1:0];
            REG_ROW_PITCH:     pitch_ff  <= csr_pwdata[PITCH_W-1:0];
            REG_PALETTE_VALID: palv_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PIXEL_FORMAT:  csr_prdata = CSR_DW'(fmt_ff);
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DW'(width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DW'(height_ff);
         REG_ROW_PITCH:     csr_prdata = CSR_DW'(pitch_ff);
         REG_PALETTE_VALID: csr_prdata = CSR_DW'(palv_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.pixel_format  = fmt_ff;
      cfg.image_width   = width_ff;
      cfg.image_height  = height_ff;
      cfg.row_pitch     = pitch_ff;
      cfg.palette_valid = palv_ff;
   end

   nftp_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   nftp_fifo #(
      .WIDTH (ItemW),
      .DEPTH (Q_DEPTH)
   ) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   nftp_back #(
      .IMAGE_BYTES     (IMAGE_BYTES),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_item     (nftp_item_type'(q_head)),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
